FILE: hdl/xlc_pkg.sv
package xlc_pkg;

    // scanner modes
    typedef enum logic [3:0] {
        M_NORMAL  = 4'd0,
        M_LT      = 4'd1,
        M_BANG    = 4'd2,
        M_PCOM    = 4'd3,
        M_PCDATA  = 4'd4,
        M_PDOCT   = 4'd5,
        M_COMMENT = 4'd6,
        M_CDATA   = 4'd7,
        M_PI      = 4'd8,
        M_DOCTYPE = 4'd9,
        M_ENTITY  = 4'd10
    } scan_mode_t;

    // reference kinds being matched after '&'
    typedef enum logic [2:0] {
        E_NONE = 3'd0,
        E_AMP  = 3'd1,
        E_APOS = 3'd2,
        E_LT   = 3'd3,
        E_GT   = 3'd4,
        E_QUOT = 3'd5,
        E_DEC  = 3'd6,
        E_HEX  = 3'd7
    } entity_kind_t;

    localparam logic [1:0] STATUS_CLEAN   = 2'd0;
    localparam logic [1:0] STATUS_COMMENT = 2'd1;
    localparam logic [1:0] STATUS_AMP     = 2'd2;

    localparam int OUT_LINE_W = 20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] PREFIX_START = 4'd3;  // "<!" plus first letter seen
    localparam logic [3:0] PREFIX_DONE  = 4'd9;
    localparam logic [2:0] DEC_MAX      = 3'd7;
    localparam logic [2:0] HEX_MAX      = 3'd6;

    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_UPPER_D = 8'h44;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_G = 8'h67;
    localparam logic [7:0] CH_LOWER_L = 8'h6C;
    localparam logic [7:0] CH_LOWER_M = 8'h6D;
    localparam logic [7:0] CH_LOWER_O = 8'h6F;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_LOWER_Q = 8'h71;
    localparam logic [7:0] CH_LOWER_S = 8'h73;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic is_nl;
        logic is_lt;
        logic is_gt;
        logic is_amp;
        logic is_bang;
        logic is_qmark;
        logic is_dash;
        logic is_lbrack;
        logic is_rbrack;
        logic is_semi;
        logic is_hash;
        logic is_upper_d;
        logic is_a;
        logic is_l;
        logic is_g;
        logic is_q;
        logic is_p;
        logic is_x;
        logic is_dec;
        logic is_hex;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        byte_class_t cls;
    } queue_item_t;

    // "<![CDATA[" by position
    function automatic logic [7:0] cdata_char(input logic [3:0] p);
        logic [7:0] c;
        case (p)
            4'd0:    c = CH_LT;
            4'd1:    c = CH_BANG;
            4'd2:    c = CH_LBRACK;
            4'd3:    c = 8'h43;
            4'd4:    c = 8'h44;
            4'd5:    c = 8'h41;
            4'd6:    c = 8'h54;
            4'd7:    c = 8'h41;
            4'd8:    c = CH_LBRACK;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "<!DOCTYPE" by position
    function automatic logic [7:0] doct_char(input logic [3:0] p);
        logic [7:0] c;
        case (p)
            4'd0:    c = CH_LT;
            4'd1:    c = CH_BANG;
            4'd2:    c = CH_UPPER_D;
            4'd3:    c = 8'h4F;
            4'd4:    c = 8'h43;
            4'd5:    c = 8'h54;
            4'd6:    c = 8'h59;
            4'd7:    c = 8'h50;
            4'd8:    c = 8'h45;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ent_char(input entity_kind_t k, input logic [1:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            E_AMP: begin
                case (p)
                    2'd0:    c = CH_LOWER_A;
                    2'd1:    c = CH_LOWER_M;
                    2'd2:    c = CH_LOWER_P;
                    default: c = 8'h00;
                endcase
            end
            E_APOS: begin
                case (p)
                    2'd0:    c = CH_LOWER_A;
                    2'd1:    c = CH_LOWER_P;
                    2'd2:    c = CH_LOWER_O;
                    default: c = CH_LOWER_S;
                endcase
            end
            E_LT: begin
                case (p)
                    2'd0:    c = CH_LOWER_L;
                    2'd1:    c = CH_LOWER_T;
                    default: c = 8'h00;
                endcase
            end
            E_GT: begin
                case (p)
                    2'd0:    c = CH_LOWER_G;
                    2'd1:    c = CH_LOWER_T;
                    default: c = 8'h00;
                endcase
            end
            E_QUOT: begin
                case (p)
                    2'd0:    c = CH_LOWER_Q;
                    2'd1:    c = CH_LOWER_U;
                    2'd2:    c = CH_LOWER_O;
                    default: c = CH_LOWER_T;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] ent_len(input entity_kind_t k);
        logic [2:0] n;
        case (k)
            E_AMP:   n = 3'd3;
            E_APOS:  n = 3'd4;
            E_LT:    n = 3'd2;
            E_GT:    n = 3'd2;
            E_QUOT:  n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: hdl/xlc_front.sv
module xlc_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] data_byte
    input  logic               s_tlast,    // last_byte
    input  logic               q_full,
    output logic               q_push,
    output xlc_pkg::queue_item_t q_item
);
    import xlc_pkg::*;

    logic [7:0] b;

    assign b        = s_tdata;
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.data_byte      = b;
        q_item.last_byte      = s_tlast;
        q_item.cls.is_nl      = (b == CH_NL);
        q_item.cls.is_lt      = (b == CH_LT);
        q_item.cls.is_gt      = (b == CH_GT);
        q_item.cls.is_amp     = (b == CH_AMP);
        q_item.cls.is_bang    = (b == CH_BANG);
        q_item.cls.is_qmark   = (b == CH_QMARK);
        q_item.cls.is_dash    = (b == CH_DASH);
        q_item.cls.is_lbrack  = (b == CH_LBRACK);
        q_item.cls.is_rbrack  = (b == CH_RBRACK);
        q_item.cls.is_semi    = (b == CH_SEMI);
        q_item.cls.is_hash    = (b == CH_HASH);
        q_item.cls.is_upper_d = (b == CH_UPPER_D);
        q_item.cls.is_a       = (b == CH_LOWER_A);
        q_item.cls.is_l       = (b == CH_LOWER_L);
        q_item.cls.is_g       = (b == CH_LOWER_G);
        q_item.cls.is_q       = (b == CH_LOWER_Q);
        q_item.cls.is_p       = (b == CH_LOWER_P);
        q_item.cls.is_x       = (b == CH_LOWER_X);
        q_item.cls.is_dec     = (b >= 8'h30) && (b <= 8'h39);
        q_item.cls.is_hex     = ((b >= 8'h30) && (b <= 8'h39))
                              || ((b >= 8'h61) && (b <= 8'h66))
                              || ((b >= 8'h41) && (b <= 8'h46));
    end

endmodule

FILE: hdl/xlc_queue.sv
module xlc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  xlc_pkg::queue_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output xlc_pkg::queue_item_t pop_item
);
    import xlc_pkg::*;

    queue_item_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_pop;

    assign full      = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/xlc_scanner.sv
module xlc_scanner #(
    parameter int LINE_WIDTH    = 20,
    parameter int BRACKET_WIDTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  xlc_pkg::queue_item_t q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata    // [1:0] status, [21:2] line_number
);
    import xlc_pkg::*;

    localparam logic signed [BRACKET_WIDTH-1:0] DEPTH_MAX =
        {1'b0, {(BRACKET_WIDTH-1){1'b1}}};
    localparam logic signed [BRACKET_WIDTH-1:0] DEPTH_MIN =
        {1'b1, {(BRACKET_WIDTH-1){1'b0}}};
    localparam logic [LINE_WIDTH-1:0] LINE_ONE = LINE_WIDTH'(1);

    scan_mode_t                       mode_reg, mode_next;
    logic [3:0]                       prefix_reg, prefix_next;
    logic [1:0]                       dash_reg, dash_next;
    logic [1:0]                       close_reg, close_next;
    logic signed [BRACKET_WIDTH-1:0]  depth_reg, depth_next;
    logic [LINE_WIDTH-1:0]            line_reg, line_next;
    logic [LINE_WIDTH-1:0]            saved_reg, saved_next;
    entity_kind_t                     ekind_reg, ekind_next;
    logic [2:0]                       eprog_reg, eprog_next;
    logic                             err_reg;

    logic                             m_valid_reg, m_valid_next;
    logic [1:0]                       m_status_reg, m_status_next;
    logic [OUT_LINE_W-1:0]            m_line_reg, m_line_next;

    logic                             again;
    logic [1:0]                       scan_status;
    logic [LINE_WIDTH-1:0]            scan_line;
    logic                             result_valid;
    logic [1:0]                       result_status;
    logic [LINE_WIDTH-1:0]            result_line;
    logic [31:0]                      result_line_wide;
    logic [7:0]                       b;
    byte_class_t                      c;
    logic [7:0]                       lit_c;

    assign b     = q_item.data_byte;
    assign c     = q_item.cls;
    assign q_pop = q_valid && (!m_valid_reg || m_tready);

    // next scanner state for the byte at the queue head
    always_comb begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        dash_next   = dash_reg;
        close_next  = close_reg;
        depth_next  = depth_reg;
        line_next   = line_reg;
        saved_next  = saved_reg;
        ekind_next  = ekind_reg;
        eprog_next  = eprog_reg;
        again       = 1'b0;
        scan_status = STATUS_CLEAN;
        scan_line   = line_reg;
        lit_c       = (mode_reg == M_PCDATA) ? cdata_char(prefix_reg) : doct_char(prefix_reg);

        unique case (mode_reg)
            M_NORMAL: again = 1'b1;
            M_LT: begin
                if (c.is_qmark) begin
                    mode_next  = M_PI;
                    close_next = 2'd0;
                end else if (c.is_bang) begin
                    mode_next = M_BANG;
                end else begin
                    again = 1'b1;
                end
            end
            M_BANG: begin
                if (c.is_dash) begin
                    mode_next = M_PCOM;
                end else if (c.is_lbrack) begin
                    mode_next   = M_PCDATA;
                    prefix_next = PREFIX_START;
                end else if (c.is_upper_d) begin
                    mode_next   = M_PDOCT;
                    prefix_next = PREFIX_START;
                end else begin
                    again = 1'b1;
                end
            end
            M_PCOM: begin
                if (c.is_dash) begin
                    mode_next = M_COMMENT;
                    dash_next = 2'd0;
                end else begin
                    again = 1'b1;
                end
            end
            M_PCDATA, M_PDOCT: begin
                if ((prefix_reg < PREFIX_DONE) && (lit_c == b)) begin
                    prefix_next = prefix_reg + 4'd1;
                    if (prefix_next == PREFIX_DONE) begin
                        if (mode_reg == M_PCDATA) begin
                            mode_next  = M_CDATA;
                            close_next = 2'd0;
                        end else begin
                            mode_next  = M_DOCTYPE;
                            depth_next = '0;
                        end
                    end
                end else begin
                    again = 1'b1;
                end
            end
            M_COMMENT: begin
                if (dash_reg == 2'd2) begin
                    if (c.is_gt) begin
                        mode_next = M_NORMAL;
                        dash_next = 2'd0;
                    end else begin
                        scan_status = STATUS_COMMENT;
                        scan_line   = line_reg;
                    end
                end else if (c.is_dash) begin
                    dash_next = dash_reg + 2'd1;
                end else begin
                    dash_next = 2'd0;
                end
            end
            M_CDATA: begin
                if (c.is_rbrack) begin
                    if (close_reg < 2'd2) begin
                        close_next = close_reg + 2'd1;
                    end
                end else if (c.is_gt && (close_reg == 2'd2)) begin
                    mode_next  = M_NORMAL;
                    close_next = 2'd0;
                end else begin
                    close_next = 2'd0;
                end
            end
            M_PI: begin
                if (c.is_qmark) begin
                    close_next = 2'd1;
                end else if (c.is_gt && (close_reg == 2'd1)) begin
                    mode_next  = M_NORMAL;
                    close_next = 2'd0;
                end else begin
                    close_next = 2'd0;
                end
            end
            M_DOCTYPE: begin
                if (c.is_lbrack) begin
                    if (depth_reg != DEPTH_MAX) begin
                        depth_next = depth_reg + 1'b1;
                    end
                end else if (c.is_rbrack) begin
                    if (depth_reg != DEPTH_MIN) begin
                        depth_next = depth_reg - 1'b1;
                    end
                end else if (c.is_gt && (depth_reg == '0)) begin
                    mode_next = M_NORMAL;
                end
            end
            M_ENTITY: begin
                unique case (ekind_reg)
                    E_NONE: begin
                        eprog_next = 3'd1;
                        if (c.is_a) begin
                            ekind_next = E_AMP;
                        end else if (c.is_l) begin
                            ekind_next = E_LT;
                        end else if (c.is_g) begin
                            ekind_next = E_GT;
                        end else if (c.is_q) begin
                            ekind_next = E_QUOT;
                        end else if (c.is_hash) begin
                            ekind_next = E_DEC;
                            eprog_next = 3'd0;
                        end else begin
                            scan_status = STATUS_AMP;
                        end
                    end
                    E_DEC: begin
                        if (c.is_dec && (eprog_reg < DEC_MAX)) begin
                            eprog_next = eprog_reg + 3'd1;
                        end else if (c.is_semi && (eprog_reg != 3'd0)) begin
                            mode_next = M_NORMAL;
                        end else if (c.is_x && (eprog_reg == 3'd0)) begin
                            ekind_next = E_HEX;
                        end else begin
                            scan_status = STATUS_AMP;
                        end
                    end
                    E_HEX: begin
                        if (c.is_hex && (eprog_reg < HEX_MAX)) begin
                            eprog_next = eprog_reg + 3'd1;
                        end else if (c.is_semi && (eprog_reg != 3'd0)) begin
                            mode_next = M_NORMAL;
                        end else begin
                            scan_status = STATUS_AMP;
                        end
                    end
                    default: begin
                        if (eprog_reg >= ent_len(ekind_reg)) begin
                            if (c.is_semi) begin
                                mode_next = M_NORMAL;
                            end else begin
                                scan_status = STATUS_AMP;
                            end
                        end else if ((ekind_reg == E_AMP) && (eprog_reg == 3'd1) && c.is_p) begin
                            // "&ap" turns into the apos branch
                            ekind_next = E_APOS;
                            eprog_next = 3'd2;
                        end else if (ent_char(ekind_reg, eprog_reg[1:0]) == b) begin
                            eprog_next = eprog_reg + 3'd1;
                        end else begin
                            scan_status = STATUS_AMP;
                        end
                    end
                endcase
                if (scan_status == STATUS_AMP) begin
                    scan_line = saved_reg;
                end
            end
            default: again = 1'b1;
        endcase

        // plain text or a broken markup prefix: scan this byte as plain text
        if (again) begin
            mode_next = M_NORMAL;
            if (c.is_lt) begin
                mode_next = M_LT;
            end else if (c.is_amp) begin
                mode_next  = M_ENTITY;
                ekind_next = E_NONE;
                eprog_next = 3'd0;
                saved_next = line_reg;
            end
        end

        // text ends inside a reference or right after a comment double dash
        if ((scan_status == STATUS_CLEAN) && q_item.last_byte) begin
            if (mode_next == M_ENTITY) begin
                scan_status = STATUS_AMP;
                scan_line   = saved_next;
            end else if ((mode_next == M_COMMENT) && (dash_next == 2'd2)) begin
                scan_status = STATUS_COMMENT;
                scan_line   = line_reg;
            end
        end

        if (c.is_nl && (line_reg != '1)) begin
            line_next = line_reg + 1'b1;
        end
    end

    // result of the head byte and the output register
    always_comb begin
        result_valid  = 1'b0;
        result_status = scan_status;
        result_line   = scan_line;
        if (!err_reg) begin
            if (scan_status != STATUS_CLEAN) begin
                result_valid = 1'b1;
            end else if (q_item.last_byte) begin
                result_valid = 1'b1;
                result_line  = line_next;
            end
        end
        result_line_wide = 32'(result_line);

        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_line_next   = m_line_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop && result_valid) begin
            m_valid_next  = 1'b1;
            m_status_next = result_status;
            m_line_next   = result_line_wide[OUT_LINE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= M_NORMAL;
            prefix_reg  <= '0;
            dash_reg    <= '0;
            close_reg   <= '0;
            depth_reg   <= '0;
            line_reg    <= LINE_ONE;
            saved_reg   <= LINE_ONE;
            ekind_reg   <= E_NONE;
            eprog_reg   <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                if (q_item.last_byte) begin
                    mode_reg   <= M_NORMAL;
                    prefix_reg <= '0;
                    dash_reg   <= '0;
                    close_reg  <= '0;
                    depth_reg  <= '0;
                    line_reg   <= LINE_ONE;
                    saved_reg  <= LINE_ONE;
                    ekind_reg  <= E_NONE;
                    eprog_reg  <= '0;
                    err_reg    <= 1'b0;
                end else if (!err_reg) begin
                    mode_reg   <= mode_next;
                    prefix_reg <= prefix_next;
                    dash_reg   <= dash_next;
                    close_reg  <= close_next;
                    depth_reg  <= depth_next;
                    line_reg   <= line_next;
                    saved_reg  <= saved_next;
                    ekind_reg  <= ekind_next;
                    eprog_reg  <= eprog_next;
                    err_reg    <= (scan_status != STATUS_CLEAN);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_line_reg   <= m_line_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_line_reg, m_status_reg};

endmodule

FILE: hdl/xml_raw_text_lexical_checker.sv
// Streaming lexical checker for raw XML text.
// Input stream (s_*): one text byte per request in s_tdata[7:0], s_tlast on
// the final byte of a text. Result stream (m_*): at most one request per
// text, m_tdata[1:0] = status (0 ok, 1 double dash in comment, 2 bare '&'),
// m_tdata[21:2] = line number (line of the fault, or final line count).
// A result goes out at the first fault; later bytes of that text are
// swallowed until tlast. A clean text reports OK on its last byte.
// Throughput: one byte per cycle while the scanner is not stalled; the scanner
// updates its whole state for each byte. An accepted byte is written into the
// queue; the scanner scans it from the queue head and registers its result.
// A 4-entry queue sits between the byte classifier and the scanner. The
// scanner stalls only while a result waits in the output register with
// m_tready low; the queue then takes up to four more bytes and s_tready
// drops. The result register holds its request until m_tready is high.
// Reset (aresetn low, synchronous) empties the queue and output register
// and returns the scanner to plain text on line one.
module xml_raw_text_lexical_checker #(
    parameter int LINE_WIDTH    = 20,   // line counter width, saturating
    parameter int BRACKET_WIDTH = 8     // signed DOCTYPE bracket depth width
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // [1:0] status, [21:2] line_number, [23:22] zero
);
    import xlc_pkg::*;

    queue_item_t push_item;
    queue_item_t head_item;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;

    // front: accept and classify bytes
    xlc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // decoupling queue between classifier and scanner
    xlc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (head_item)
    );

    // back: scanner state machine plus result register
    xlc_scanner #(
        .LINE_WIDTH    (LINE_WIDTH),
        .BRACKET_WIDTH (BRACKET_WIDTH)
    ) u_scanner (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
